FILE: src/ssrg_pkg.sv
// Shared types, constants and the sine table builder for the supply sag ripple gain block.
package ssrg_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam logic signed [15:0] HARMONIC_MIX = 16'sd0;

  localparam int SIN_ENTRIES = (1 << (SINE_TABLE_BITS - 2)) + 1;
  localparam int SIN_IDX_W = SINE_TABLE_BITS - 1;
  localparam int PHASE_LSB = 16 - SINE_TABLE_BITS;

  localparam logic signed [17:0] TWO_OVER_PI = 18'sd10430;
  localparam int SIN_A = 25736;
  localparam int SIN_B = 10583;
  localparam int SIN_C = 1231;
  localparam int Q14_ONE = 16384;

  localparam int NUM_REGS = 8;
  localparam int ADDR_W = $clog2(NUM_REGS * 4);
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_SAG_START,
    REG_SAG_SPAN_INVERSE,
    REG_SAG_GAIN_PER_LOAD,
    REG_RIPPLE_GAIN_BASE,
    REG_RIPPLE_GAIN_SLOPE,
    REG_GAIN_FLOOR,
    REG_GAIN_CEILING,
    REG_PHASE_STEP
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] sag_start;
    logic [15:0]        sag_span_inverse;
    logic signed [15:0] sag_gain_per_load;
    logic signed [15:0] ripple_gain_base;
    logic signed [15:0] ripple_gain_slope;
    logic [15:0]        gain_floor;
    logic [15:0]        gain_ceiling;
    logic [15:0]        phase_step;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SAG,
    ST_SLOPE,
    ST_HARM,
    ST_GAIN,
    ST_WLO,
    ST_WHI,
    ST_RLO,
    ST_RHI,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SAG,
    OP_SLOPE,
    OP_HARM,
    OP_GAIN,
    OP_WLO,
    OP_WHI,
    OP_RLO,
    OP_RHI,
    OP_OUT
  } op_e;

  typedef struct packed {
    logic take;
    op_e  op;
  } cmd_t;

  typedef logic [14:0] sin_rom_t [SIN_ENTRIES];

  function automatic sin_rom_t build_sin_rom();
    sin_rom_t rom;
    int x;
    int x2;
    int t;
    int s;
    for (int i = 0; i < SIN_ENTRIES; i++) begin
      x = i << PHASE_LSB;
      x2 = (x * x) >> 14;
      t = (SIN_C * x2) >> 14;
      t = ((SIN_B - t) * x2) >> 14;
      s = ((SIN_A - t) * x) >> 14;
      if (s > Q14_ONE) begin
        s = Q14_ONE;
      end
      rom[i] = 15'(s);
    end
    return rom;
  endfunction

  function automatic logic [SIN_IDX_W-1:0] sin_index(input logic [15:0] angle);
    logic [15:0] q;
    logic [14:0] x;
    q = angle & ~16'((1 << PHASE_LSB) - 1);
    if (q[14]) begin
      x = 15'(15'd16384 - {1'b0, q[13:0]});
    end else begin
      x = {1'b0, q[13:0]};
    end
    return x[14:PHASE_LSB];
  endfunction

endpackage

FILE: src/ssrg_regs.sv
// Configuration register bank with an APB-style access port.
module ssrg_regs import ssrg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  localparam cfg_t CFG_RESET = '{
    sag_start:         16'sd0,
    sag_span_inverse:  16'd4096,
    sag_gain_per_load: 16'sd0,
    ripple_gain_base:  16'sd0,
    ripple_gain_slope: 16'sd0,
    gain_floor:        16'd0,
    gain_ceiling:      16'd0,
    phase_step:        16'd0
  };

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SAG_START:         cfg_d.sag_start         = pwdata[15:0];
        REG_SAG_SPAN_INVERSE:  cfg_d.sag_span_inverse  = pwdata[15:0];
        REG_SAG_GAIN_PER_LOAD: cfg_d.sag_gain_per_load = pwdata[15:0];
        REG_RIPPLE_GAIN_BASE:  cfg_d.ripple_gain_base  = pwdata[15:0];
        REG_RIPPLE_GAIN_SLOPE: cfg_d.ripple_gain_slope = pwdata[15:0];
        REG_GAIN_FLOOR:        cfg_d.gain_floor        = pwdata[15:0];
        REG_GAIN_CEILING:      cfg_d.gain_ceiling      = pwdata[15:0];
        REG_PHASE_STEP:        cfg_d.phase_step        = pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SAG_START:         prdata = {16'b0, cfg_q.sag_start};
      REG_SAG_SPAN_INVERSE:  prdata = {16'b0, cfg_q.sag_span_inverse};
      REG_SAG_GAIN_PER_LOAD: prdata = {16'b0, cfg_q.sag_gain_per_load};
      REG_RIPPLE_GAIN_BASE:  prdata = {16'b0, cfg_q.ripple_gain_base};
      REG_RIPPLE_GAIN_SLOPE: prdata = {16'b0, cfg_q.ripple_gain_slope};
      REG_GAIN_FLOOR:        prdata = {16'b0, cfg_q.gain_floor};
      REG_GAIN_CEILING:      prdata = {16'b0, cfg_q.gain_ceiling};
      REG_PHASE_STEP:        prdata = {16'b0, cfg_q.phase_step};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: src/ssrg_ctrl.sv
// Sequencing state machine that steps the shared multiplier through one item.
module ssrg_ctrl import ssrg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  logic ripple_i,
  output cmd_t cmd_o
);

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_SAG;
      ST_SAG:   state_d = ripple_i ? ST_SLOPE : ST_OUT;
      ST_SLOPE: state_d = ST_HARM;
      ST_HARM:  state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_WLO;
      ST_WLO:   state_d = ST_WHI;
      ST_WHI:   state_d = ST_RLO;
      ST_RLO:   state_d = ST_RHI;
      ST_RHI:   state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.take   = 1'b0;
    cmd_o.op     = OP_NONE;
    out_valid_d  = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_LOAD:  cmd_o.op = OP_LOAD;
      ST_SAG:   cmd_o.op = OP_SAG;
      ST_SLOPE: cmd_o.op = OP_SLOPE;
      ST_HARM:  cmd_o.op = OP_HARM;
      ST_GAIN:  cmd_o.op = OP_GAIN;
      ST_WLO:   cmd_o.op = OP_WLO;
      ST_WHI:   cmd_o.op = OP_WHI;
      ST_RLO:   cmd_o.op = OP_RLO;
      ST_RHI:   cmd_o.op = OP_RHI;
      ST_OUT: begin
        if (out_free) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: src/ssrg_dp.sv
// Datapath with the shared multiplier, sine table, ripple phase and result register.
module ssrg_dp import ssrg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  input  logic signed [15:0] sag_env_i,
  input  logic signed [15:0] branch_depth_i,
  input  logic               advance_phase_i,
  output logic               ripple_o,
  output logic [15:0]        supply_scale_o
);

  localparam sin_rom_t SIN_ROM = build_sin_rom();

  logic signed [16:0] diff_q;
  logic signed [15:0] depth_q;
  logic               adv_q;
  logic [14:0]        load_q;
  logic signed [31:0] s28_q;
  logic [14:0]        s1_q;
  logic signed [31:0] sum_q;
  logic signed [17:0] w_q;
  logic signed [34:0] g_q;
  logic signed [49:0] acc_q;
  logic signed [23:0] f_q;
  logic signed [25:0] r_q;
  logic [15:0]        scale_q;
  logic [15:0]        phase_q;
  logic [14:0]        rom_q;

  logic [14:0]          load_d;
  logic signed [31:0]   s28_d;
  logic signed [31:0]   sum_d;
  logic signed [17:0]   w_d;
  logic signed [23:0]   f_d;
  logic signed [25:0]   r_d;
  logic [15:0]          scale_d;
  logic signed [16:0]   diff_d;

  logic                 rom_rd;
  logic [SIN_IDX_W-1:0] rom_addr;
  logic signed [17:0]   s2;
  logic signed [31:0]   mul_a;
  logic signed [17:0]   mul_b;
  logic signed [49:0]   mul_p;
  logic [21:0]          load_raw;
  logic                 diff_pos;
  logic signed [51:0]   wg;
  logic signed [37:0]   f28;
  logic signed [53:0]   rt;
  logic signed [25:0]   r_sel;
  logic signed [25:0]   r_c;
  logic [15:0]          lo;
  logic [15:0]          hi;

  assign ripple_o       = !depth_q[15] && (depth_q != '0);
  assign supply_scale_o = scale_q;

  assign diff_d = $signed({sag_env_i[15], sag_env_i}) -
                  $signed({cfg_i.sag_start[15], cfg_i.sag_start});

  assign rom_rd   = (cmd_i.op == OP_LOAD) || (cmd_i.op == OP_SAG);
  assign rom_addr = (cmd_i.op == OP_LOAD) ? sin_index(phase_q)
                                          : sin_index({phase_q[14:0], 1'b0});
  assign s2 = phase_q[14] ? -$signed({3'b0, rom_q}) : $signed({3'b0, rom_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_LOAD: begin
        mul_a = $signed({16'b0, cfg_i.sag_span_inverse});
        mul_b = {diff_q[16], diff_q};
      end
      OP_SAG: begin
        mul_a = {{16{cfg_i.sag_gain_per_load[15]}}, cfg_i.sag_gain_per_load};
        mul_b = $signed({3'b0, load_q});
      end
      OP_SLOPE: begin
        mul_a = {{16{cfg_i.ripple_gain_slope[15]}}, cfg_i.ripple_gain_slope};
        mul_b = $signed({3'b0, load_q});
      end
      OP_HARM: begin
        mul_a = {{16{HARMONIC_MIX[15]}}, HARMONIC_MIX};
        mul_b = s2;
      end
      OP_GAIN: begin
        mul_a = sum_q;
        mul_b = {{2{depth_q[15]}}, depth_q};
      end
      OP_WLO: begin
        mul_a = {{14{w_q[17]}}, w_q};
        mul_b = $signed({1'b0, g_q[16:0]});
      end
      OP_WHI: begin
        mul_a = {{14{w_q[17]}}, w_q};
        mul_b = g_q[34:17];
      end
      OP_RLO: begin
        mul_a = s28_q;
        mul_b = $signed({1'b0, f_q[16:0]});
      end
      OP_RHI: begin
        mul_a = s28_q;
        mul_b = {{11{f_q[23]}}, f_q[23:17]};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign diff_pos = !diff_q[16] && (diff_q != '0);
  assign load_raw = mul_p[31:10];
  assign load_d   = !diff_pos ? 15'd0 :
                    (load_raw > 22'd16384) ? 15'd16384 : load_raw[14:0];

  assign s28_d = 32'sd268435456 - $signed(mul_p[31:0]);
  assign sum_d = $signed({{2{cfg_i.ripple_gain_base[15]}}, cfg_i.ripple_gain_base, 14'b0}) +
                 $signed(mul_p[31:0]);
  assign w_d   = $signed({3'b0, s1_q}) - TWO_OVER_PI + $signed(mul_p[31:14]);

  assign wg  = $signed({mul_p[34:0], 17'b0}) + $signed({{2{acc_q[49]}}, acc_q});
  assign f28 = $signed(wg[51:14]) + 38'sd268435456;
  assign f_d = f28[37:14];

  assign rt  = $signed({mul_p[36:0], 17'b0}) + $signed({{4{acc_q[49]}}, acc_q});
  assign r_d = rt[53:28];

  assign lo    = (cfg_i.gain_floor < cfg_i.gain_ceiling) ? cfg_i.gain_floor : cfg_i.gain_ceiling;
  assign hi    = (cfg_i.gain_floor < cfg_i.gain_ceiling) ? cfg_i.gain_ceiling : cfg_i.gain_floor;
  assign r_sel = ripple_o ? r_q : {{8{s28_q[31]}}, s28_q[31:14]};

  always_comb begin
    r_c = r_sel;
    if (hi != '0) begin
      if (r_c < $signed({10'b0, lo})) begin
        r_c = $signed({10'b0, lo});
      end
      if (r_c > $signed({10'b0, hi})) begin
        r_c = $signed({10'b0, hi});
      end
    end
    if (r_c[25]) begin
      scale_d = 16'd0;
    end else if (r_c > 26'sd65535) begin
      scale_d = 16'hFFFF;
    end else begin
      scale_d = r_c[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      diff_q  <= diff_d;
      depth_q <= branch_depth_i;
      adv_q   <= advance_phase_i;
    end
    if (rom_rd) begin
      rom_q <= SIN_ROM[rom_addr];
    end
    unique case (cmd_i.op)
      OP_LOAD:  load_q <= load_d;
      OP_SAG: begin
        s28_q <= s28_d;
        s1_q  <= rom_q;
      end
      OP_SLOPE: sum_q   <= sum_d;
      OP_HARM:  w_q     <= w_d;
      OP_GAIN:  g_q     <= mul_p[46:12];
      OP_WLO:   acc_q   <= mul_p;
      OP_WHI:   f_q     <= f_d;
      OP_RLO:   acc_q   <= mul_p;
      OP_RHI:   r_q     <= r_d;
      OP_OUT:   scale_q <= scale_d;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if ((cmd_i.op == OP_OUT) && adv_q) begin
      phase_q <= phase_q + cfg_i.phase_step;
    end
  end

endmodule

FILE: src/supply_sag_ripple_gain_top.sv
// Top level of the supply sag ripple gain block.
//
//   Channel  Direction  Handshake                   Payload
//   input    in         in_valid_i / in_ready_o     sag_env_i, branch_depth_i, advance_phase_i
//   output   out        out_valid_o / out_ready_i   supply_scale_o
//   config   in         psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// An item runs the load, sag and output steps when the branch depth is not positive and every
// step otherwise; the controller steps one shared 32x18 multiplier through each product.
// A new item is taken in the idle cycle even while the previous result waits in the
// output register; the item then holds in its last step until that register is free.
// Reset returns the controller, the configuration registers and the ripple phase to their
// reset values at once.
module supply_sag_ripple_gain_top import ssrg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sag_env_i,
  input  logic signed [15:0] branch_depth_i,
  input  logic               advance_phase_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        supply_scale_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cfg_t cfg;
  cmd_t cmd;
  logic ripple;

  ssrg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ssrg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ripple_i    (ripple),
    .cmd_o       (cmd)
  );

  ssrg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .sag_env_i       (sag_env_i),
    .branch_depth_i  (branch_depth_i),
    .advance_phase_i (advance_phase_i),
    .ripple_o        (ripple),
    .supply_scale_o  (supply_scale_o)
  );

endmodule
